[src/musical_bar_beat_tick_counter_top_assert.svh]
// Assertion macros shared by the checker of the bar/beat/tick timebase.
`ifndef MUSICAL_BAR_BEAT_TICK_COUNTER_TOP_ASSERT_SVH
`define MUSICAL_BAR_BEAT_TICK_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define MBBT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timebase check failed");

// Next-cycle implication, ignored while reset is high.
`define MBBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timebase check failed");

// Next-cycle implication that also holds across reset.
`define MBBT_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("timebase check failed");

`endif

[src/mbbt_pkg.sv]
// ----------------------------------------------------------------------------
// mbbt_pkg
// Types and constants shared by the bar/beat/tick timebase modules.
// ----------------------------------------------------------------------------
package mbbt_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_SAMPLE_RATE   = 3'd0;
  localparam logic [2:0] CFG_TEMPO_BPM     = 3'd1;
  localparam logic [2:0] CFG_TICKS_IN_BEAT = 3'd2;
  localparam logic [2:0] CFG_BEATS_IN_BAR  = 3'd3;

  // Register reset values
  localparam logic [17:0] RST_SAMPLE_RATE   = 18'd48000;
  localparam logic [9:0]  RST_TEMPO_BPM     = 10'd120;
  localparam logic [15:0] RST_TICKS_IN_BEAT = 16'd1920;
  localparam logic [5:0]  RST_BEATS_IN_BAR  = 6'd4;

  // Port widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Divider iterations, one quotient bit each
  localparam logic [6:0] DIV_STEPS = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_A, ST_MUL_B, ST_DIV_TIME, ST_WAIT_TIME, ST_DIV_TICK,
    ST_WAIT_TICK, ST_DIV_BEAT, ST_WAIT_BEAT, ST_MUL_C, ST_MUL_D, ST_COMMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL_A, OP_MUL_B, OP_DIV_TIME, OP_DIV_TICK,
    OP_DIV_BEAT, OP_MUL_C, OP_MUL_D, OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

endpackage

[src/musical_bar_beat_tick_counter_top.sv]
// Each item runs three 64-step divisions in the shared one-bit-per-cycle
//   divider; a new item is accepted only after the last result is committed.
// Reset: synchronous; registers return to 48000 Hz, 120 bpm, 1920 ticks,
//   4 beats, position bar 1 beat 1 tick 0, and the next item rebuilds.
// ----------------------------------------------------------------------------
// musical_bar_beat_tick_counter_top
// Bar/beat/tick transport timebase, one result per audio period.
// ----------------------------------------------------------------------------
module musical_bar_beat_tick_counter_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [15:0] period_frames, [47:16] frame_position
  input  logic [mbbt_pkg::IN_DATA_W-1:0]     s_tdata,
  // [0] relocate
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [31:0] bar_number, [37:32] beat_number, [53:38] tick_number,
  // [93:54] bar_start
  output logic [mbbt_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mbbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbbt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mbbt_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  mbbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  mbbt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata)
  );

endmodule

[src/mbbt_ctrl.sv]
// ----------------------------------------------------------------------------
// mbbt_ctrl
// Sequencer: steps the datapath through multiply and divide operations.
// ----------------------------------------------------------------------------
module mbbt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output mbbt_pkg::cmd_t  cmd,
  input  mbbt_pkg::status_t status
);
  import mbbt_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  // State register and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_COMMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_MUL_A;
      ST_MUL_A:     state_next = ST_MUL_B;
      ST_MUL_B:     state_next = ST_DIV_TIME;
      ST_DIV_TIME:  state_next = ST_WAIT_TIME;
      ST_WAIT_TIME: if (!status.div_busy) state_next = ST_DIV_TICK;
      ST_DIV_TICK:  state_next = ST_WAIT_TICK;
      ST_WAIT_TICK: if (!status.div_busy) state_next = ST_DIV_BEAT;
      ST_DIV_BEAT:  state_next = ST_WAIT_BEAT;
      ST_WAIT_BEAT: if (!status.div_busy) state_next = ST_MUL_C;
      ST_MUL_C:     state_next = ST_MUL_D;
      ST_MUL_D:     state_next = ST_COMMIT;
      ST_COMMIT:    if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    s_tready = 1'b0;
    cmd.op   = OP_NONE;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) cmd.op = OP_LOAD;
      end
      ST_MUL_A:    cmd.op = OP_MUL_A;
      ST_MUL_B:    cmd.op = OP_MUL_B;
      ST_DIV_TIME: cmd.op = OP_DIV_TIME;
      ST_DIV_TICK: cmd.op = OP_DIV_TICK;
      ST_DIV_BEAT: cmd.op = OP_DIV_BEAT;
      ST_MUL_C:    cmd.op = OP_MUL_C;
      ST_MUL_D:    cmd.op = OP_MUL_D;
      ST_COMMIT:   if (out_free) cmd.op = OP_COMMIT;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

[src/mbbt_dp.sv]
// ----------------------------------------------------------------------------
// mbbt_dp
// Datapath: config registers, position state, 64x16 multiplier and a
// radix-2 restoring divider.
// ----------------------------------------------------------------------------
module mbbt_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [mbbt_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                 s_tuser,
  input  logic                                 cfg_we,
  input  logic [mbbt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbbt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  mbbt_pkg::cmd_t                       cmd,
  output mbbt_pkg::status_t                    status,
  output logic [mbbt_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import mbbt_pkg::*;

  // Configuration
  logic [17:0] sample_rate;
  logic [9:0]  tempo_bpm;
  logic [15:0] ticks_in_beat;
  logic [5:0]  beats_in_bar;
  logic        pending;

  // Position state
  logic [31:0] cur_bar;
  logic [5:0]  cur_beat;
  logic [15:0] cur_tick;
  logic [39:0] cur_bar_start;

  // Working registers
  logic        mode;       // 1: rebuild from frame position
  logic [63:0] acc;
  logic [63:0] dvd;        // dividend, then quotient
  logic [23:0] rem;
  logic [23:0] dsr;
  logic [6:0]  div_cnt;
  logic [15:0] tick_new;
  logic [5:0]  beat_m1;
  logic [31:0] bars;

  // Effective settings, zero treated as one
  logic [17:0] rate_eff;
  logic [15:0] tpb_eff;
  logic [5:0]  bpb_eff;
  logic [23:0] divisor;

  assign rate_eff = (sample_rate == '0) ? 18'd1 : sample_rate;
  assign tpb_eff  = (ticks_in_beat == '0) ? 16'd1 : ticks_in_beat;
  assign bpb_eff  = (beats_in_bar == '0) ? 6'd1 : beats_in_bar;
  // rate * 60 = rate * 64 - rate * 4
  assign divisor  = {rate_eff, 6'b0} - {4'b0, rate_eff, 2'b0};

  // Multiplier operand select
  logic [63:0] mul_a;
  logic [15:0] mul_b;
  logic [63:0] prod;

  always_comb begin
    mul_a = acc;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_A: mul_b = mode ? {6'b0, tempo_bpm} : tpb_eff;
      OP_MUL_B: mul_b = mode ? tpb_eff : {6'b0, tempo_bpm};
      OP_MUL_C: begin
        mul_a = dvd;
        mul_b = {10'b0, bpb_eff};
      end
      OP_MUL_D: mul_b = tpb_eff;
      default:  mul_b = '0;
    endcase
  end

  assign prod = mul_a * {48'b0, mul_b};

  // One restoring divide step
  logic [24:0] trial;
  logic [24:0] diff;
  logic        q_bit;

  assign trial = {rem, dvd[63]};
  assign diff  = trial - {1'b0, dsr};
  assign q_bit = trial >= {1'b0, dsr};

  assign status.div_busy = (div_cnt != '0);

  assign m_tdata = {2'b0, cur_bar_start, cur_tick, cur_beat, cur_bar};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate   <= RST_SAMPLE_RATE;
      tempo_bpm     <= RST_TEMPO_BPM;
      ticks_in_beat <= RST_TICKS_IN_BEAT;
      beats_in_bar  <= RST_BEATS_IN_BAR;
      pending       <= 1'b1;
      cur_bar       <= 32'd1;
      cur_beat      <= 6'd1;
      cur_tick      <= '0;
      cur_bar_start <= '0;
      div_cnt       <= '0;
    end else begin
      // Divider iteration
      if (div_cnt != '0) begin
        rem     <= q_bit ? diff[23:0] : trial[23:0];
        dvd     <= {dvd[62:0], q_bit};
        div_cnt <= div_cnt - 7'd1;
      end

      case (cmd.op)
        OP_LOAD: begin
          mode    <= s_tuser | pending;
          acc     <= (s_tuser | pending) ? {32'b0, s_tdata[47:16]}
                                         : {48'b0, s_tdata[15:0]};
          pending <= 1'b0;
        end
        OP_MUL_A, OP_MUL_B, OP_MUL_D: acc <= prod;
        OP_DIV_TIME: begin
          dvd     <= acc;
          dsr     <= divisor;
          rem     <= '0;
          div_cnt <= DIV_STEPS;
        end
        OP_DIV_TICK: begin
          dvd     <= mode ? dvd : dvd + {48'b0, cur_tick};
          dsr     <= {8'b0, tpb_eff};
          rem     <= '0;
          div_cnt <= DIV_STEPS;
        end
        OP_DIV_BEAT: begin
          tick_new <= rem[15:0];
          dvd      <= mode ? dvd : dvd + {58'b0, 6'(cur_beat - 6'd1)};
          dsr      <= {18'b0, bpb_eff};
          rem      <= '0;
          div_cnt  <= DIV_STEPS;
        end
        OP_MUL_C: begin
          acc     <= prod;
          beat_m1 <= rem[5:0];
          bars    <= dvd[31:0];
        end
        OP_COMMIT: begin
          cur_beat <= beat_m1 + 6'd1;
          cur_tick <= tick_new;
          if (mode) begin
            cur_bar       <= bars + 32'd1;
            cur_bar_start <= acc[39:0];
          end else begin
            cur_bar       <= cur_bar + bars;
            cur_bar_start <= cur_bar_start + acc[39:0];
          end
        end
        default: ;
      endcase

      // Register writes; any listed register forces a rebuild
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_RATE: begin
            sample_rate <= cfg_data;
            pending     <= 1'b1;
          end
          CFG_TEMPO_BPM: begin
            tempo_bpm <= cfg_data[9:0];
            pending   <= 1'b1;
          end
          CFG_TICKS_IN_BEAT: begin
            ticks_in_beat <= cfg_data[15:0];
            pending       <= 1'b1;
          end
          CFG_BEATS_IN_BAR: begin
            beats_in_bar <= cfg_data[5:0];
            pending      <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[src/mbbt_checker.sv]
// ----------------------------------------------------------------------------
// mbbt_checker
// Port-level checks of the timebase, bound to the top level.
// ----------------------------------------------------------------------------
`include "musical_bar_beat_tick_counter_top_assert.svh"

module mbbt_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [mbbt_pkg::IN_DATA_W-1:0]     s_tdata,
  input logic                               s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [mbbt_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [mbbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [mbbt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // No result is pending right after reset
  `MBBT_ASSERT_ALWAYS(a_rst_no_result, rst, !m_tvalid)

  // One item at a time: input closes after a transfer
  `MBBT_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)

  // Beat shown is never zero
  `MBBT_ASSERT_NOW(a_beat_nonzero, m_tvalid, m_tdata[37:32] != 6'd0)

  // A stalled result holds
  `MBBT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind musical_bar_beat_tick_counter_top mbbt_checker u_mbbt_checker (.*);

[tb/musical_bar_beat_tick_counter_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// musical_bar_beat_tick_counter_checker
// Watches the input, result and register channels of the bar/beat/tick
// timebase, keeps its own copy of the transport position, and compares
// every result transfer field by field with the oldest predicted position.
// ----------------------------------------------------------------------------
module musical_bar_beat_tick_counter_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [mbbt_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [mbbt_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mbbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbbt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              pending,
  output int                              periods_seen,
  output int                              relocates_seen
);
  import mbbt_pkg::*;

  // Position as packed on m_tdata, lowest field last
  typedef struct packed {
    logic [1:0]  pad;
    logic [39:0] bar_start;
    logic [15:0] tick;
    logic [5:0]  beat;
    logic [31:0] bar;
  } position_t;

  position_t positions_due[$];

  // Timebase registers and position state
  logic [17:0] rate_reg;
  logic [9:0]  bpm_reg;
  logic [15:0] tpb_reg;
  logic [5:0]  bpb_reg;
  logic [63:0] bar_q, beat_q, tick_q, bar_start_q;
  logic        rebuild_due;

  // Advance one audio period or rebuild it; returns the new position
  function automatic position_t step_position(input logic [15:0] frames,
                                              input logic [31:0] frame,
                                              input logic reloc);
    logic [63:0] rate, tpb, bpb, divisor, whole_ticks, whole_beats, bar0;
    logic [63:0] total, beat_pos, bars_adv;
    position_t p;
    rate = (rate_reg == 0) ? 64'd1 : 64'(rate_reg);
    tpb = (tpb_reg == 0) ? 64'd1 : 64'(tpb_reg);
    bpb = (bpb_reg == 0) ? 64'd1 : 64'(bpb_reg);
    divisor = rate * 64'd60;
    if (reloc || rebuild_due) begin
      whole_ticks = (64'(frame) * 64'(bpm_reg) * tpb) / divisor;
      whole_beats = whole_ticks / tpb;
      bar0 = whole_beats / bpb;
      beat_q = whole_beats - bar0 * bpb + 1;
      tick_q = whole_ticks - whole_beats * tpb;
      bar_start_q = (bar0 * bpb * tpb) & 64'hFF_FFFF_FFFF;
      bar_q = (bar0 + 1) & 64'hFFFF_FFFF;
      rebuild_due = 1'b0;
    end else begin
      total = tick_q + (64'(frames) * tpb * 64'(bpm_reg)) / divisor;
      tick_q = total % tpb;
      beat_pos = (beat_q - 1) + total / tpb;
      bars_adv = beat_pos / bpb;
      beat_q = beat_pos % bpb + 1;
      bar_q = (bar_q + bars_adv) & 64'hFFFF_FFFF;
      bar_start_q = (bar_start_q + bars_adv * bpb * tpb) & 64'hFF_FFFF_FFFF;
    end
    p.pad = '0;
    p.bar = bar_q[31:0];
    p.beat = beat_q[5:0];
    p.tick = tick_q[15:0];
    p.bar_start = bar_start_q[39:0];
    return p;
  endfunction

  task automatic report_field(input string fname, input logic [39:0] exp_v,
                              input logic [39:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, fname,
                 exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    position_t exp_p, got_p;
    if (rst) begin
      rate_reg = RST_SAMPLE_RATE;
      bpm_reg = RST_TEMPO_BPM;
      tpb_reg = RST_TICKS_IN_BEAT;
      bpb_reg = RST_BEATS_IN_BAR;
      bar_q = 1;
      beat_q = 1;
      tick_q = 0;
      bar_start_q = 0;
      rebuild_due = 1'b1;
      positions_due.delete();
      errors = 0;
      periods_seen = 0;
      relocates_seen = 0;
    end else begin
      // result transfer
      if (m_tvalid && m_tready) begin
        got_p = position_t'(m_tdata);
        if (positions_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result with nothing expected", $realtime);
        end else begin
          exp_p = positions_due.pop_front();
          report_field("bar_number", 40'(exp_p.bar), 40'(got_p.bar));
          report_field("beat_number", 40'(exp_p.beat), 40'(got_p.beat));
          report_field("tick_number", 40'(exp_p.tick), 40'(got_p.tick));
          report_field("bar_start", exp_p.bar_start, got_p.bar_start);
          report_field("padding", 40'(exp_p.pad), 40'(got_p.pad));
        end
      end
      // register write; unknown indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMPLE_RATE:   begin rate_reg = cfg_data; rebuild_due = 1'b1; end
          CFG_TEMPO_BPM:     begin bpm_reg = cfg_data[9:0]; rebuild_due = 1'b1; end
          CFG_TICKS_IN_BEAT: begin tpb_reg = cfg_data[15:0]; rebuild_due = 1'b1; end
          CFG_BEATS_IN_BAR:  begin bpb_reg = cfg_data[5:0]; rebuild_due = 1'b1; end
          default: ;
        endcase
      end
      // period transfer
      if (s_tvalid && s_tready) begin
        positions_due.insert(positions_due.size(),
                             step_position(s_tdata[15:0], s_tdata[47:16], s_tuser));
        periods_seen++;
        if (s_tuser) relocates_seen++;
      end
    end
    pending = positions_due.size();
  end
endmodule

[tb/musical_bar_beat_tick_counter_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// musical_bar_beat_tick_counter_top_tb
// Drives audio periods and register writes into the timebase with bursty
// input and stalling output; the checker predicts and compares positions.
// ----------------------------------------------------------------------------
module musical_bar_beat_tick_counter_top_tb;
  import mbbt_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // [15:0] period_frames, [47:16] frame_position
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // [0] relocate
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [31:0] bar_number, [37:32] beat_number, [53:38] tick_number,
  // [93:54] bar_start
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int errors, pending, periods_seen, relocates_seen;
  int burst_left = 0;
  int cycle_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  musical_bar_beat_tick_counter_top uut (.*);
  musical_bar_beat_tick_counter_checker chk (.*);

  initial begin
    #30ms;
    $display("timeout with %0d positions outstanding", pending);
    $display("musical_bar_beat_tick_counter_top_tb: done, errors");
    $finish;
  end

  // Receiver: mixed stall patterns, plus one long hold-off to back up the input
  always @(negedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= 30000 && cycle_cnt < 33000) m_tready <= 1'b0;
    else if ((cycle_cnt / 4000) % 3 == 0) m_tready <= 1'b1;
    else if ((cycle_cnt / 4000) % 3 == 1) m_tready <= ($urandom_range(3) != 0);
    else m_tready <= ($urandom_range(7) < 2);
  end

  // Send one period; between bursts the valid drops for a random gap
  task automatic send_period(input logic [15:0] frames, input logic [31:0] frame,
                             input logic reloc);
    s_tdata <= {frame, frames};
    s_tuser <= reloc;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(12);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(300)) @(negedge clk);
    end
  endtask

  // Let the block drain before touching registers
  task automatic settle;
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (210) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [17:0] rate, input logic [9:0] bpm,
                           input logic [15:0] tpb, input logic [5:0] bpb);
    settle();
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_TEMPO_BPM, 18'(bpm));
    write_reg(CFG_TICKS_IN_BEAT, 18'(tpb));
    write_reg(CFG_BEATS_IN_BAR, 18'(bpb));
  endtask

  task automatic random_periods(input int n);
    logic [15:0] frames;
    repeat (n) begin
      case ($urandom_range(9))
        0: frames = 16'hFFFF;
        1: frames = 16'd0;
        2, 3: frames = 16'($urandom);
        default: frames = 16'($urandom_range(2048, 64));
      endcase
      send_period(frames, $urandom, $urandom_range(9) == 0);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default registers: first period rebuilds, then advances and relocates
    send_period(16'd512, 32'd96000, 1'b0);
    send_period(16'd0, 32'hFFFF_FFFF, 1'b0);
    send_period(16'hFFFF, 32'd0, 1'b0);
    send_period(16'd1024, 32'hFFFF_FFFF, 1'b1);
    send_period(16'hFFFF, 32'd0, 1'b0);
    send_period(16'd100, 32'd0, 1'b1);

    // Unknown register indexes change nothing and request no rebuild
    settle();
    for (int k = 1; k <= 4; k++) write_reg(CFG_BEATS_IN_BAR + 3'(k), 18'h3FFFF);
    send_period(16'd4800, 32'd1234567, 1'b0);

    // Zero registers read as one, bar wraps, bar_start wraps
    load_regs(18'd0, 10'd1023, 16'd1, 6'd0);
    send_period(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_period(16'hFFFF, 32'd0, 1'b0);
    load_regs(18'd1, 10'd1023, 16'd65535, 6'd63);
    send_period(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_period(16'hFFFF, 32'd0, 1'b0);
    send_period(16'hFFFF, 32'd0, 1'b0);
    load_regs(18'h3FFFF, 10'd1, 16'd0, 6'd32);
    send_period(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_period(16'hFFFF, 32'd0, 1'b0);

    // Zero tempo: rebuild lands at bar 1 and nothing advances
    load_regs(18'd8000, 10'd0, 16'd65535, 6'd1);
    send_period(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_period(16'hFFFF, 32'd0, 1'b0);

    // Random phases under edge and typical settings
    load_regs(18'd192000, 10'd999, 16'd65535, 6'd32);
    random_periods(100);
    load_regs(18'd8000, 10'd1, 16'd1, 6'd1);
    random_periods(100);
    load_regs(18'd44100, 10'd120, 16'd960, 6'd4);
    random_periods(150);
    load_regs(18'd8000, 10'd999, 16'd1, 6'd2);
    random_periods(100);
    for (int ph = 0; ph < 4; ph++) begin
      load_regs(18'($urandom_range(192000, 8000)), 10'($urandom_range(999, 1)),
                16'($urandom_range(65535, 1)), 6'($urandom_range(32, 1)));
      random_periods(85);
    end

    settle();
    repeat (50) @(negedge clk);
    $display("covered %0d audio periods (%0d relocates) over 13 register settings,",
             periods_seen, relocates_seen);
    $display("including zero registers, bar and bar_start wrap, and a long output stall");
    if (errors == 0) $display("musical_bar_beat_tick_counter_top_tb: done, clean");
    else $display("musical_bar_beat_tick_counter_top_tb: done, errors");
    $finish;
  end
endmodule

[files.f]
+incdir+src
src/mbbt_pkg.sv
src/mbbt_ctrl.sv
src/mbbt_dp.sv
src/musical_bar_beat_tick_counter_top.sv
src/mbbt_checker.sv
tb/musical_bar_beat_tick_counter_checker.sv
tb/musical_bar_beat_tick_counter_top_tb.sv
